/* hdl/ovsn_pkg.sv */
// ----------------------------------------------------------------------------
// Same-norm orthogonal vector: shared definitions
// Types and constants that do not depend on the component width.
// ----------------------------------------------------------------------------
package ovsn_pkg;

	// Number of vector components, one datapath lane each.
	localparam int NLANE = 3;

	// Bit positions in the output tuser.
	localparam int USER_W       = 2;
	localparam int USER_ON_LINE = 0;
	localparam int USER_CLIPPED = 1;

	// Per-word control bits that travel beside the lane data.
	typedef struct packed {
		logic       on_line;
		logic [2:0] neg;
	} side_t;

endpackage

/* hdl/orthogonal_vector_same_norm.sv */
// ----------------------------------------------------------------------------
// Same-norm orthogonal vector
// Forms (y+z, z-x, -x-y) from an input 3-vector and rescales it to the input's
// length with round-half-away rounding and saturation.
// ----------------------------------------------------------------------------
// Usage: one input word may be accepted every cycle while the pipeline is
// not stalled. From input acceptance to output valid a word passes six front
// stages (input, raw vector, squares, sums, partial products, numerator),
// 2*COMP_WIDTH+2 restoring divider stages that give one quotient bit each,
// COMP_WIDTH+1 square root stages that give one root bit each, and the output
// register. The pipeline advances as a whole; while the output word is held
// by a low m_axis_tready, no new input word is taken.
// Each component m is the largest integer with (2m-1)^2 <= floor(N/D), with
// N = 4*r^2*|P|^2 and D = |r|^2, so the rounding is exact.
module orthogonal_vector_same_norm #(
	parameter int COMP_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: comp_x, comp_y, comp_z (lowest bits first), zero padded
	input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: orth_x, orth_y, orth_z (lowest bits first), zero padded
	output logic [((3*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// tuser: on_line, clipped (lowest bit first)
	output logic [ovsn_pkg::USER_W-1:0]        m_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready
);

	localparam int W   = COMP_WIDTH;
	localparam int HW  = W + 1;               // half width of product operands
	localparam int PW  = 2 * HW;              // squares, sums, partial products
	localparam int NW  = 4 * W + 2;           // numerator width
	localparam int QW  = 2 * W + 2;           // quotient width
	localparam int DW  = 2 * W + 2;           // divisor and remainder width
	localparam int SRW = W + 3;               // square root remainder width
	localparam int TDW = ((3 * W + 7) / 8) * 8;
	localparam int NL  = ovsn_pkg::NLANE;

	logic ce;

	// The whole pipeline moves when the output register is free or being read.
	assign ce            = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = ce;

	// ------------------------------------------------------------------
	// Stage 1: input register.
	logic         vld_s1;
	logic [W-1:0] x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s1 <= s_axis_tdata[W-1:0];
			y_s1 <= s_axis_tdata[2*W-1:W];
			z_s1 <= s_axis_tdata[3*W-1:2*W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: raw orthogonal vector and magnitudes.
	logic signed [W:0]   xe, ye, ze;
	logic signed [W+1:0] r_c [NL];
	logic signed [W+1:0] rn_c [NL];
	logic [W:0]          rmag_c [NL];
	logic [NL-1:0]       rneg_c;
	logic signed [W:0]   xn_c, yn_c, zn_c;

	always_comb begin
		xe = $signed({x_s1[W-1], x_s1});
		ye = $signed({y_s1[W-1], y_s1});
		ze = $signed({z_s1[W-1], z_s1});
		xn_c = -xe;
		yn_c = -ye;
		zn_c = -ze;
		r_c[0] = (W+2)'(ye) + (W+2)'(ze);
		r_c[1] = (W+2)'(ze) - (W+2)'(xe);
		r_c[2] = -(W+2)'(xe) - (W+2)'(ye);
		for (int l = 0; l < NL; l++) begin
			rn_c[l]   = -r_c[l];
			rneg_c[l] = r_c[l][W+1];
			rmag_c[l] = rneg_c[l] ? rn_c[l][W:0] : r_c[l][W:0];
		end
	end

	logic         vld_s2;
	logic [W-1:0] xmag_s2, ymag_s2, zmag_s2;
	logic [W:0]   rmag_s2 [NL];
	logic [NL-1:0] rneg_s2;
	logic         xneg_s2;
	logic         degen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			xmag_s2  <= x_s1[W-1] ? xn_c[W-1:0] : x_s1;
			ymag_s2  <= y_s1[W-1] ? yn_c[W-1:0] : y_s1;
			zmag_s2  <= z_s1[W-1] ? zn_c[W-1:0] : z_s1;
			rmag_s2  <= rmag_c;
			rneg_s2  <= rneg_c;
			xneg_s2  <= x_s1[W-1];
			degen_s2 <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: squares of the input and raw components.
	logic             vld_s3;
	logic [2*W-1:0]   xsq_s3, ysq_s3, zsq_s3;
	logic [PW-1:0]    rsq_s3 [NL];
	ovsn_pkg::side_t  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			xsq_s3 <= (2*W)'(xmag_s2) * (2*W)'(xmag_s2);
			ysq_s3 <= (2*W)'(ymag_s2) * (2*W)'(ymag_s2);
			zsq_s3 <= (2*W)'(zmag_s2) * (2*W)'(zmag_s2);
			for (int l = 0; l < NL; l++) begin
				rsq_s3[l] <= PW'(rmag_s2[l]) * PW'(rmag_s2[l]);
			end
			side_s3.on_line <= degen_s2;
			// On the degenerate line the first two outputs follow the sign of x.
			side_s3.neg     <= degen_s2 ? {1'b0, xneg_s2, xneg_s2} : rneg_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: squared norms; the degenerate line uses N = 12x^2, D = 2.
	logic            vld_s4;
	logic [PW-1:0]   np_s4, den_s4;
	logic [PW-1:0]   rsq_s4 [NL];
	ovsn_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			np_s4   <= PW'(xsq_s3) + PW'(ysq_s3) + PW'(zsq_s3);
			den_s4  <= side_s3.on_line ? PW'(2) : rsq_s3[0] + rsq_s3[1] + rsq_s3[2];
			rsq_s4[0] <= side_s3.on_line ? PW'(1) : rsq_s3[0];
			rsq_s4[1] <= side_s3.on_line ? PW'(1) : rsq_s3[1];
			rsq_s4[2] <= side_s3.on_line ? '0 : rsq_s3[2];
			side_s4 <= side_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: partial products of r^2 * |P|^2 on half-width operands.
	logic            vld_s5;
	logic [PW-1:0]   pp_hh_s5 [NL];
	logic [PW-1:0]   pp_hl_s5 [NL];
	logic [PW-1:0]   pp_lh_s5 [NL];
	logic [PW-1:0]   pp_ll_s5 [NL];
	logic [PW-1:0]   den_s5;
	ovsn_pkg::side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (ce) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < NL; l++) begin
				pp_hh_s5[l] <= PW'(rsq_s4[l][PW-1:HW]) * PW'(np_s4[PW-1:HW]);
				pp_hl_s5[l] <= PW'(rsq_s4[l][PW-1:HW]) * PW'(np_s4[HW-1:0]);
				pp_lh_s5[l] <= PW'(rsq_s4[l][HW-1:0])  * PW'(np_s4[PW-1:HW]);
				pp_ll_s5[l] <= PW'(rsq_s4[l][HW-1:0])  * PW'(np_s4[HW-1:0]);
			end
			den_s5  <= den_s4;
			side_s5 <= side_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: numerator N = 4 * r^2 * |P|^2.
	logic [2*PW-1:0] nsum_c [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			nsum_c[l] = {pp_hh_s5[l], {PW{1'b0}}}
				+ {{HW{1'b0}}, pp_hl_s5[l], {HW{1'b0}}}
				+ {{HW{1'b0}}, pp_lh_s5[l], {HW{1'b0}}}
				+ {{PW{1'b0}}, pp_ll_s5[l]};
		end
	end

	logic            vld_s6;
	logic [NW-1:0]   n_s6 [NL];
	logic [DW-1:0]   den_s6;
	ovsn_pkg::side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < NL; l++) begin
				n_s6[l] <= {nsum_c[l][NW-3:0], 2'b00};
			end
			den_s6  <= den_s5;
			side_s6 <= side_s5;
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider: one quotient bit per stage, quotient shifts in
	// where the numerator bits shift out.
	logic            dv_vld_s  [QW];
	logic [DW-1:0]   dv_den_s  [QW];
	ovsn_pkg::side_t dv_side_s [QW];
	logic [DW-1:0]   dv_rem_s  [NL][QW];
	logic [QW-1:0]   dv_qn_s   [NL][QW];

	for (genvar k = 0; k < QW; k++) begin : gen_dv_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (ce) begin
				dv_vld_s[k] <= (k == 0) ? vld_s6 : dv_vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				dv_den_s[k]  <= (k == 0) ? den_s6 : dv_den_s[(k == 0) ? 0 : k-1];
				dv_side_s[k] <= (k == 0) ? side_s6 : dv_side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	for (genvar l = 0; l < NL; l++) begin : gen_dv_lane
		for (genvar k = 0; k < QW; k++) begin : gen_dv_stage
			logic [DW-1:0] rem_in, den_in, rem_out;
			logic [QW-1:0] qn_in;
			logic [DW:0]   sh;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_in = DW'(n_s6[l][NW-1:QW]);
				assign qn_in  = n_s6[l][QW-1:0];
				assign den_in = den_s6;
			end else begin : g_next
				assign rem_in = dv_rem_s[l][k-1];
				assign qn_in  = dv_qn_s[l][k-1];
				assign den_in = dv_den_s[k-1];
			end

			// Trial subtract of the divisor from the shifted remainder.
			always_comb begin
				sh      = {rem_in, qn_in[QW-1]};
				ge      = sh >= {1'b0, den_in};
				rem_out = ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					dv_rem_s[l][k] <= rem_out;
					dv_qn_s[l][k]  <= {qn_in[QW-2:0], ge};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Integer square root of the quotient: one root bit per stage.
	localparam int SQN = W + 1;

	logic            sq_vld_s  [SQN];
	ovsn_pkg::side_t sq_side_s [SQN];
	logic [SRW-1:0]  sq_rem_s  [NL][SQN];
	logic [W:0]      sq_root_s [NL][SQN];
	logic [QW-1:0]   sq_q_s    [NL][SQN];

	for (genvar j = 0; j < SQN; j++) begin : gen_sq_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (ce) begin
				sq_vld_s[j] <= (j == 0) ? dv_vld_s[QW-1] : sq_vld_s[(j == 0) ? 0 : j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sq_side_s[j] <= (j == 0) ? dv_side_s[QW-1] : sq_side_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	for (genvar l = 0; l < NL; l++) begin : gen_sq_lane
		for (genvar j = 0; j < SQN; j++) begin : gen_sq_stage
			logic [SRW-1:0] rem_in, rem_out;
			logic [W:0]     root_in;
			logic [QW-1:0]  q_in;
			logic [SRW+1:0] sh, trial;
			logic           ge;

			if (j == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
				assign q_in    = dv_qn_s[l][QW-1];
			end else begin : g_next
				assign rem_in  = sq_rem_s[l][j-1];
				assign root_in = sq_root_s[l][j-1];
				assign q_in    = sq_q_s[l][j-1];
			end

			// Bring down two bits and try 4*root + 1.
			always_comb begin
				sh      = {rem_in, q_in[QW-1:QW-2]};
				trial   = {2'b00, root_in, 2'b01};
				ge      = sh >= trial;
				rem_out = ge ? SRW'(sh - trial) : sh[SRW-1:0];
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					sq_rem_s[l][j]  <= rem_out;
					sq_root_s[l][j] <= {root_in[W-1:0], ge};
					sq_q_s[l][j]    <= {q_in[QW-3:0], 2'b00};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output: m = (s+1)/2, saturation, sign, and the output register.
	logic [W+1:0]  sp1_c [NL];
	logic [W:0]    m_c   [NL];
	logic [W:0]    lim_c [NL];
	logic [W:0]    mm_c  [NL];
	logic [W:0]    sv_c  [NL];
	logic [NL-1:0] clip_c;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			sp1_c[l]  = {1'b0, sq_root_s[l][SQN-1]} + (W+2)'(1);
			m_c[l]    = sp1_c[l][W+1:1];
			lim_c[l]  = sq_side_s[SQN-1].neg[l] ? (W+1)'(1) << (W-1)
				: ((W+1)'(1) << (W-1)) - (W+1)'(1);
			clip_c[l] = m_c[l] > lim_c[l];
			mm_c[l]   = clip_c[l] ? lim_c[l] : m_c[l];
			sv_c[l]   = sq_side_s[SQN-1].neg[l] ? -mm_c[l] : mm_c[l];
		end
	end

	logic         out_vld_q;
	logic [W-1:0] orth_q [NL];
	logic         on_line_q, clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ce) begin
			out_vld_q <= sq_vld_s[SQN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < NL; l++) begin
				orth_q[l] <= sv_c[l][W-1:0];
			end
			on_line_q <= sq_side_s[SQN-1].on_line;
			clipped_q <= |clip_c;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TDW'({orth_q[2], orth_q[1], orth_q[0]});

	always_comb begin
		m_axis_tuser = '0;
		m_axis_tuser[ovsn_pkg::USER_ON_LINE] = on_line_q;
		m_axis_tuser[ovsn_pkg::USER_CLIPPED] = clipped_q;
	end

	// ------------------------------------------------------------------
	// Assertions.

	// The divider remainder always ends below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[QW-1] |-> (dv_rem_s[0][QW-1] < dv_den_s[QW-1])
			&& (dv_rem_s[1][QW-1] < dv_den_s[QW-1])
			&& (dv_rem_s[2][QW-1] < dv_den_s[QW-1]))
		else $error("divider remainder not below divisor");

	// On the degenerate line the third component is zero.
	a_line_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && on_line_q |-> orth_q[2] == '0)
		else $error("on_line word with nonzero third component");

	// On the degenerate line the first two components match.
	a_line_xy: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && on_line_q |-> orth_q[0] == orth_q[1])
		else $error("on_line word with unequal first components");

	// A clipped word holds at least one component at a rail.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && clipped_q |->
			(orth_q[0] == {1'b1, {(W-1){1'b0}}}) || (orth_q[0] == {1'b0, {(W-1){1'b1}}})
			|| (orth_q[1] == {1'b1, {(W-1){1'b0}}}) || (orth_q[1] == {1'b0, {(W-1){1'b1}}})
			|| (orth_q[2] == {1'b1, {(W-1){1'b0}}}) || (orth_q[2] == {1'b0, {(W-1){1'b1}}}))
		else $error("clipped word without a saturated component");

endmodule
